### src/csdm_pkg.sv
// Shared types, widths and constants for the concentric square-to-disk map.
`timescale 1ns / 1ps
package csdm_pkg;

   localparam int COORD_W = 16;             // input and output coordinate width
   localparam int REM_W   = 18;             // divider partial remainder
   localparam int DEN_W   = 17;             // divisor / radius, up to 1.0 in Q1.16
   localparam int QUO_W   = 31;             // ratio magnitude, up to 1.0 in Q1.30
   localparam int DIV_CELLS = QUO_W;        // one quotient bit per cell
   localparam int ANG_W   = 32;             // CORDIC datapath, Q2.30
   localparam int ATAN_ENTRIES = 24;

   localparam logic [29:0] PI4_Q30      = 30'd843314857;
   localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;

   typedef enum logic [1:0] {
      SECTOR_EAST  = 2'd0,
      SECTOR_NORTH = 2'd1,
      SECTOR_WEST  = 2'd2,
      SECTOR_SOUTH = 2'd3
   } csdm_sector_type;

   typedef struct packed {
      csdm_sector_type sector;
      logic            neg;     // ratio sign
   } csdm_side_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic signed [ANG_W-1:0] csdm_atan(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 32'sd843314856;
         5'd1:    v = 32'sd497837829;
         5'd2:    v = 32'sd263043836;
         5'd3:    v = 32'sd133525158;
         5'd4:    v = 32'sd67021686;
         5'd5:    v = 32'sd33543515;
         5'd6:    v = 32'sd16775850;
         5'd7:    v = 32'sd8388437;
         5'd8:    v = 32'sd4194282;
         5'd9:    v = 32'sd2097149;
         5'd10:   v = 32'sd1048575;
         5'd11:   v = 32'sd524287;
         5'd12:   v = 32'sd262143;
         5'd13:   v = 32'sd131071;
         5'd14:   v = 32'sd65535;
         5'd15:   v = 32'sd32767;
         5'd16:   v = 32'sd16383;
         5'd17:   v = 32'sd8191;
         5'd18:   v = 32'sd4095;
         5'd19:   v = 32'sd2047;
         5'd20:   v = 32'sd1023;
         5'd21:   v = 32'sd511;
         5'd22:   v = 32'sd255;
         5'd23:   v = 32'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### src/csdm_div_cell.sv
// One restoring-division cell: resolves one ratio bit and passes the remainder on.
`timescale 1ns / 1ps
module csdm_div_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         prev_valid,
   input  logic [csdm_pkg::REM_W-1:0]   prev_rem,
   input  logic [csdm_pkg::DEN_W-1:0]   prev_den,
   input  logic [csdm_pkg::QUO_W-1:0]   prev_quo,
   input  csdm_pkg::csdm_side_type      prev_side,
   output logic                         next_valid,
   output logic [csdm_pkg::REM_W-1:0]   next_rem,
   output logic [csdm_pkg::DEN_W-1:0]   next_den,
   output logic [csdm_pkg::QUO_W-1:0]   next_quo,
   output csdm_pkg::csdm_side_type      next_side
);
   import csdm_pkg::*;

   logic                 valid_ff;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   csdm_side_type        side_ff;
   logic                 fits;
   logic [REM_W-1:0]     diff;

   always_comb begin
      fits   = prev_rem >= {1'b0, prev_den};
      diff   = fits ? (prev_rem - {1'b0, prev_den}) : prev_rem;
      rem_in = {diff[REM_W-2:0], 1'b0};
      quo_in = {prev_quo[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         den_ff  <= prev_den;
         quo_ff  <= quo_in;
         side_ff <= prev_side;
      end
   end

   assign next_valid = valid_ff;
   assign next_rem   = rem_ff;
   assign next_den   = den_ff;
   assign next_quo   = quo_ff;
   assign next_side  = side_ff;

endmodule

### src/csdm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent step.
`timescale 1ns / 1ps
module csdm_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               prev_valid,
   input  logic signed [csdm_pkg::ANG_W-1:0]  prev_x,
   input  logic signed [csdm_pkg::ANG_W-1:0]  prev_y,
   input  logic signed [csdm_pkg::ANG_W-1:0]  prev_z,
   input  csdm_pkg::csdm_side_type            prev_side,
   output logic                               next_valid,
   output logic signed [csdm_pkg::ANG_W-1:0]  next_x,
   output logic signed [csdm_pkg::ANG_W-1:0]  next_y,
   output logic signed [csdm_pkg::ANG_W-1:0]  next_z,
   output csdm_pkg::csdm_side_type            next_side
);
   import csdm_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_STEP = csdm_atan(5'(STAGE));

   logic                    valid_ff;
   logic signed [ANG_W-1:0] x_ff, x_in;
   logic signed [ANG_W-1:0] y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   csdm_side_type           side_ff;
   logic signed [ANG_W-1:0] dx, dy;

   always_comb begin
      dx = prev_y >>> STAGE;
      dy = prev_x >>> STAGE;
      if (!prev_z[ANG_W-1]) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - ATAN_STEP;
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= prev_side;
      end
   end

   assign next_valid = valid_ff;
   assign next_x     = x_ff;
   assign next_y     = y_ff;
   assign next_z     = z_ff;
   assign next_side  = side_ff;

endmodule

### src/concentric_square_to_disk_map.sv
// Top level: concentric square-to-disk mapping with divider and CORDIC cell chains.
//
//   channel | direction | tdata (low bit first)        | tuser
//   req_    | in        | square_x[15:0], square_y     | none
//   rsp_    | out       | disk_x[15:0], disk_y         | none
//
// One transaction per cycle sustained while the output is accepted; a result passes
// the front end, 31 divider cells, multiply stage, CORDIC cells and output register.
// All stages advance together unless the last CORDIC cell holds a result that
// the output register cannot take; while that cell is empty the chain keeps moving.
// Synchronous reset clears valid bits only.
`timescale 1ns / 1ps
module concentric_square_to_disk_map #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // square_x[15:0], square_y[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // disk_x[15:0], disk_y[31:16]
);
   import csdm_pkg::*;

   logic advance, out_load;

   // ---------------- front end ----------------
   logic signed [18:0] ax, bx, r_s, num_s;
   csdm_sector_type    sector;
   logic [DEN_W-1:0]   num_abs;

   always_comb begin
      ax = 19'(signed'({1'b0, req_tdata[15:0], 1'b0})) - 19'sd65536;
      bx = 19'(signed'({1'b0, req_tdata[31:16], 1'b0})) - 19'sd65536;
      if (ax > -bx) begin
         if (ax > bx) begin
            sector = SECTOR_EAST;  r_s = ax;  num_s = bx;
         end else begin
            sector = SECTOR_NORTH; r_s = bx;  num_s = -ax;
         end
      end else begin
         if (ax < bx) begin
            sector = SECTOR_WEST;  r_s = -ax; num_s = -bx;
         end else begin
            sector = SECTOR_SOUTH; r_s = -bx;
            num_s  = (bx != 19'sd0) ? ax : 19'sd0;
         end
      end
      num_abs = num_s[18] ? DEN_W'(-num_s) : num_s[DEN_W-1:0];
   end

   logic              front_valid_ff;
   logic [REM_W-1:0]  front_rem_ff;
   logic [DEN_W-1:0]  front_den_ff;
   csdm_side_type     front_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_rem_ff  <= {1'b0, num_abs};
         front_den_ff  <= r_s[DEN_W-1:0];
         front_side_ff <= '{sector, num_s[18]};
      end
   end

   // ---------------- divider chain ----------------
   logic                dv   [DIV_CELLS+1];
   logic [REM_W-1:0]    drem [DIV_CELLS+1];
   logic [DEN_W-1:0]    dden [DIV_CELLS+1];
   logic [QUO_W-1:0]    dquo [DIV_CELLS+1];
   csdm_side_type       dside[DIV_CELLS+1];

   assign dv[0]    = front_valid_ff;
   assign drem[0]  = front_rem_ff;
   assign dden[0]  = front_den_ff;
   assign dquo[0]  = '0;
   assign dside[0] = front_side_ff;

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      csdm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .prev_valid (dv[k]),
         .prev_rem   (drem[k]),
         .prev_den   (dden[k]),
         .prev_quo   (dquo[k]),
         .prev_side  (dside[k]),
         .next_valid (dv[k+1]),
         .next_rem   (drem[k+1]),
         .next_den   (dden[k+1]),
         .next_quo   (dquo[k+1]),
         .next_side  (dside[k+1])
      );
   end

   // ---------------- angle and start vector ----------------
   // a zero radius gives a zero start vector, so the angle there is irrelevant
   logic [QUO_W+29:0]       theta_prod;
   logic [DEN_W+29:0]       x0_prod;
   logic signed [ANG_W-1:0] theta_in, x0_in;
   logic                    mul_valid_ff;
   logic signed [ANG_W-1:0] theta_ff, x0_ff;
   csdm_side_type           mul_side_ff;

   always_comb begin
      theta_prod = dquo[DIV_CELLS] * PI4_Q30;
      x0_prod    = dden[DIV_CELLS] * GAIN_INV_Q30;
      theta_in   = {1'b0, theta_prod[QUO_W+29:30]};
      if (dside[DIV_CELLS].neg) begin
         theta_in = -theta_in;
      end
      x0_in = {1'b0, x0_prod[DEN_W+29:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= dv[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         theta_ff    <= theta_in;
         x0_ff       <= x0_in;
         mul_side_ff <= dside[DIV_CELLS];
      end
   end

   // ---------------- CORDIC chain ----------------
   logic                    cv   [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0] cx   [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0] cy   [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0] cz   [CORDIC_STAGES+1];
   csdm_side_type           cside[CORDIC_STAGES+1];

   assign cv[0]    = mul_valid_ff;
   assign cx[0]    = x0_ff;
   assign cy[0]    = '0;
   assign cz[0]    = theta_ff;
   assign cside[0] = mul_side_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      csdm_cordic_cell #(.STAGE(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .prev_valid (cv[i]),
         .prev_x     (cx[i]),
         .prev_y     (cy[i]),
         .prev_z     (cz[i]),
         .prev_side  (cside[i]),
         .next_valid (cv[i+1]),
         .next_x     (cx[i+1]),
         .next_y     (cy[i+1]),
         .next_z     (cz[i+1]),
         .next_side  (cside[i+1])
      );
   end

   // ---------------- sector rotation, rounding, output ----------------
   logic signed [ANG_W:0]   cos_e, sin_e, ox, oy;
   logic signed [ANG_W+1:0] ox_r, oy_r;
   logic signed [18:0]      ox_q, oy_q;
   logic [COORD_W-1:0]      disk_x, disk_y;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;

   always_comb begin
      cos_e = {cx[CORDIC_STAGES][ANG_W-1], cx[CORDIC_STAGES]};
      sin_e = {cy[CORDIC_STAGES][ANG_W-1], cy[CORDIC_STAGES]};
      case (cside[CORDIC_STAGES].sector)
         SECTOR_EAST:  begin ox = cos_e;  oy = sin_e;  end
         SECTOR_NORTH: begin ox = -sin_e; oy = cos_e;  end
         SECTOR_WEST:  begin ox = -cos_e; oy = -sin_e; end
         default:      begin ox = sin_e;  oy = -cos_e; end
      endcase
      ox_r = {ox[ANG_W], ox} + 34'sd16384;
      oy_r = {oy[ANG_W], oy} + 34'sd16384;
      ox_q = ox_r[ANG_W+1:15];
      oy_q = oy_r[ANG_W+1:15];
      if (ox_q > 19'sd32767) begin
         disk_x = 16'h7fff;
      end else if (ox_q < -19'sd32768) begin
         disk_x = 16'h8000;
      end else begin
         disk_x = ox_q[COORD_W-1:0];
      end
      if (oy_q > 19'sd32767) begin
         disk_y = 16'h7fff;
      end else if (oy_q < -19'sd32768) begin
         disk_y = 16'h8000;
      end else begin
         disk_y = oy_q[COORD_W-1:0];
      end
   end

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = out_load || !cv[CORDIC_STAGES];
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cv[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {disk_y, disk_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_ready_when_tail_empty: assert property (@(posedge clock) disable iff (reset)
      !cv[CORDIC_STAGES] |-> req_tready)
      else $error("input stalled with an empty tail cell");

   a_ratio_bounded: assert property (@(posedge clock) disable iff (reset)
      (dv[DIV_CELLS] && dden[DIV_CELLS] != '0) |-> (dquo[DIV_CELLS] <= 31'h4000_0000))
      else $error("coordinate ratio exceeds one");

   a_angle_bounded: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && x0_ff != '0) |->
         (theta_ff <= 32'sd843314857 && theta_ff >= -32'sd843314857))
      else $error("angle outside one octant");

   a_tail_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && cv[CORDIC_STAGES]) |=>
         (cv[CORDIC_STAGES] && $stable(cx[CORDIC_STAGES]) && $stable(cy[CORDIC_STAGES])))
      else $error("tail result lost during output stall");
`endif

endmodule

### sim/concentric_square_to_disk_map_test.sv
// Self-checking testbench for the concentric square-to-disk map: bit-exact prediction and scoreboard.
`timescale 1ns / 1ps
module concentric_square_to_disk_map_test;
   import csdm_pkg::*;

   localparam int STAGES         = 16;
   localparam int LATENCY        = STAGES + 34;
   localparam int RANDOM_POINTS  = 1630;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 22;

   // corners, center, axes, diagonals, points right next to the center and one next to a corner
   localparam logic [15:0] EDGE_X [DIRECTED_COUNT] = '{
      16'd32768, 16'd0,     16'd65535, 16'd0,     16'd65535, 16'd32768,
      16'd32768, 16'd0,     16'd65535, 16'd49152, 16'd16384, 16'd49152,
      16'd16384, 16'd32769, 16'd32768, 16'd32767, 16'd32768, 16'd32769,
      16'd32767, 16'd32769, 16'd32767, 16'd65535
   };
   localparam logic [15:0] EDGE_Y [DIRECTED_COUNT] = '{
      16'd32768, 16'd0,     16'd65535, 16'd65535, 16'd0,     16'd0,
      16'd65535, 16'd32768, 16'd32768, 16'd49152, 16'd49152, 16'd16384,
      16'd16384, 16'd32768, 16'd32769, 16'd32768, 16'd32767, 16'd32769,
      16'd32767, 16'd32767, 16'd32769, 16'd1
   };

   typedef longint unsigned u64_type;

   typedef struct {
      logic [15:0]        square_x;
      logic [15:0]        square_y;
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } disk_point_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_BURSTY,
      RX_SPARSE
   } rx_mode_type;

   class disk_point_ledger;
      localparam longint PI4_SCALED  = 64'sd843314857;
      localparam longint GAIN_SCALED = 64'sd652032874;
      localparam int     ATAN_DEPTH  = 24;
      localparam longint ATAN_SCALED [ATAN_DEPTH] = '{
         64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
         64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
         64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
         64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
         64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
         64'sd1023,      64'sd511,       64'sd255,       64'sd127
      };

      disk_point_type pending_points[$];
      int             noted;
      int             checked;
      int             errors;
      int             sector_hits[4];

      function new();
         noted = 0;
         checked = 0;
         errors = 0;
         foreach (sector_hits[i]) sector_hits[i] = 0;
      endfunction

      function logic signed [15:0] to_q15(input longint v);
         longint q;
         q = (v + 64'sd16384) >>> 15;
         if (q > 32767) q = 32767;
         else if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      function void map_point(input logic [15:0] sx, input logic [15:0] sy,
                              output logic signed [15:0] px, output logic signed [15:0] py,
                              output csdm_sector_type sect);
         longint  a, b, radius, num, den, ratio, theta, cx, cy, z, step_x, step_y, ox, oy;
         u64_type mag;
         a = 2 * longint'(sx) - 65536;
         b = 2 * longint'(sy) - 65536;
         if (a > -b) begin
            if (a > b) begin
               sect = SECTOR_EAST;  radius = a;  num = b;  den = a;
            end else begin
               sect = SECTOR_NORTH; radius = b;  num = -a; den = b;
            end
         end else if (a < b) begin
            sect = SECTOR_WEST; radius = -a; num = -b; den = -a;
         end else begin
            sect = SECTOR_SOUTH; radius = -b;
            num = (b != 0) ? a : 0;
            den = (b != 0) ? -b : 1;
         end
         if (den <= 0) begin
            ratio = 0;
         end else begin
            mag = u64_type'(num < 0 ? -num : num);
            mag = (mag << 30) / u64_type'(den);
            ratio = (num < 0) ? -longint'(mag) : longint'(mag);
         end
         mag = u64_type'(ratio < 0 ? -ratio : ratio);
         mag = (mag * u64_type'(PI4_SCALED)) >> 30;
         theta = (ratio < 0) ? -longint'(mag) : longint'(mag);

         cx = (radius * 64'sd16384 * GAIN_SCALED) >>> 30;
         cy = 0;
         z  = theta;
         for (int i = 0; i < STAGES && i < ATAN_DEPTH; i++) begin
            step_x = cy >>> i;
            step_y = cx >>> i;
            if (z >= 0) begin
               cx = cx - step_x; cy = cy + step_y; z = z - ATAN_SCALED[i];
            end else begin
               cx = cx + step_x; cy = cy - step_y; z = z + ATAN_SCALED[i];
            end
         end

         case (sect)
            SECTOR_EAST:  begin ox = cx;  oy = cy;  end
            SECTOR_NORTH: begin ox = -cy; oy = cx;  end
            SECTOR_WEST:  begin ox = -cx; oy = -cy; end
            default:      begin ox = cy;  oy = -cx; end
         endcase
         px = to_q15(ox);
         py = to_q15(oy);
      endfunction

      task report_mismatch(input string what);
         errors++;
         if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      function void note_square_point(input logic [15:0] sx, input logic [15:0] sy);
         disk_point_type  p;
         csdm_sector_type sect;
         p.square_x = sx;
         p.square_y = sy;
         map_point(sx, sy, p.disk_x, p.disk_y, sect);
         sector_hits[int'(sect)]++;
         pending_points = {pending_points, p};
         noted++;
      endfunction

      task check_disk_point(input logic signed [15:0] got_x, input logic signed [15:0] got_y);
         disk_point_type want;
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result (%0d, %0d)", got_x, got_y));
            return;
         end
         want = pending_points.pop_front();
         checked++;
         if (got_x !== want.disk_x)
            report_mismatch($sformatf("square (%0d,%0d): disk_x %0d, expected %0d",
                                      want.square_x, want.square_y, got_x, want.disk_x));
         if (got_y !== want.disk_y)
            report_mismatch($sformatf("square (%0d,%0d): disk_y %0d, expected %0d",
                                      want.square_x, want.square_y, got_y, want.disk_y));
      endtask

      task check_drained();
         while (pending_points.size() != 0) begin
            report_mismatch($sformatf("no result for square (%0d,%0d)",
                                      pending_points[0].square_x,
                                      pending_points[0].square_y));
            void'(pending_points.pop_front());
         end
      endtask

      function int pending();
         return pending_points.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   disk_point_ledger ledger;

   concentric_square_to_disk_map #(
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_point(input logic [15:0] sx, input logic [15:0] sy);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {sy, sx};
      do @(posedge clock); while (!req_tready);
      ledger.note_square_point(sx, sy);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = $urandom;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic pick_point(output logic [15:0] sx, output logic [15:0] sy);
      int offset;
      sx = 16'($urandom);
      sy = 16'($urandom);
      case ($urandom_range(0, 9))
         6: begin
            // on or next to a sector boundary
            offset = $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) sy = 16'(int'(sx) + offset);
            else sy = 16'(65536 - int'(sx) + offset);
         end
         7: begin
            // close to the center
            sx = 16'(32768 + int'($urandom_range(0, 128)) - 64);
            sy = 16'(32768 + int'($urandom_range(0, 128)) - 64);
         end
         8: begin
            if ($urandom_range(0, 1)) sx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else sy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         9: begin
            sx = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                      : 16'($urandom_range(65280, 65535));
            sy = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                      : 16'($urandom_range(65280, 65535));
         end
         default: ;
      endcase
   endtask

   // receiver: ready pattern switches between randomly chosen modes
   initial begin : receiver
      rx_mode_type mode;
      int          left;
      int          stall;
      rsp_tready = 1'b0;
      mode  = RX_OPEN;
      left  = 0;
      stall = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(100, 400);
         end
         left--;
         case (mode)
            RX_OPEN: rsp_tready = 1'b1;
            RX_COIN: rsp_tready = 1'($urandom_range(0, 1));
            RX_BURSTY: begin
               if (stall > 0) begin
                  stall--;
                  rsp_tready = 1'b0;
               end else if ($urandom_range(0, 15) == 0) begin
                  stall = $urandom_range(5, 30);
                  rsp_tready = 1'b0;
               end else begin
                  rsp_tready = 1'b1;
               end
            end
            default: rsp_tready = (left % 4 == 0);
         endcase
      end
   end

   // result monitor and watchdog
   initial begin : monitor
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            ledger.check_disk_point(rsp_tdata[15:0], rsp_tdata[31:16]);
         if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))) quiet = 0;
         else quiet++;
      end
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] sx;
      logic [15:0] sy;
      int          sent;
      int          burst;
      ledger     = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_point(EDGE_X[i], EDGE_Y[i]);
         if (i % 5 == 4) pause_sender($urandom_range(1, 3));
      end

      sent = 0;
      while (sent < RANDOM_POINTS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
         if (burst > RANDOM_POINTS - sent) burst = RANDOM_POINTS - sent;
         repeat (burst) begin
            pick_point(sx, sy);
            send_point(sx, sy);
            sent++;
         end
         pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 4));
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      ledger.check_drained();

      $display("mapped %0d square points (%0d directed), checked %0d disk points, %0d errors",
               ledger.noted, DIRECTED_COUNT, ledger.checked, ledger.errors);
      $display("sector hits east %0d, north %0d, west %0d, south %0d",
               ledger.sector_hits[SECTOR_EAST], ledger.sector_hits[SECTOR_NORTH],
               ledger.sector_hits[SECTOR_WEST], ledger.sector_hits[SECTOR_SOUTH]);
      if (ledger.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
